[src/b85_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b85_pkg
// Shared types and constants for the base-85 (btoa) decoder.
// ----------------------------------------------------------------------------
package b85_pkg;

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
  localparam logic [7:0] CHAR_DIGIT_LO = 8'h21;  // '!'
  localparam logic [7:0] CHAR_DIGIT_HI = 8'h75;  // 'u'
  localparam logic [7:0] CHAR_ZERO_WORD = 8'h7a; // 'z'

  localparam logic [31:0] RADIX = 32'd85;

  localparam logic [2:0] GROUP_LAST_DIGIT = 3'd4;
  localparam logic [1:0] LAST_BYTE_IDX    = 2'd3;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic        err;   // emit a single error result
    logic [31:0] word;  // decoded word, bytes emitted MSB first
  } cmd_t;

endpackage
`default_nettype wire

[src/base85_btoa_decoder.sv]
`default_nettype none
// A character that completes a group, a 'z' or an error shows its first
// result after the queue and the output register. Characters are taken one
// per cycle while the queue has room; results leave at one per cycle while
// out_tready is high, so a run of 'z' characters is paced by the result port
// at four bytes each. Reset (rst_n low, synchronous) clears the partial word,
// digit count, error flag, checksums, queue and output valid.
// ----------------------------------------------------------------------------
// base85_btoa_decoder
// Base-85 (btoa) stream decoder with running XOR, sum and rotate checksums.
// ----------------------------------------------------------------------------
module base85_btoa_decoder
  import b85_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [7:0] data_byte, [15:8] xor_check,
                                       // [47:16] sum_check, [79:48] rot_check
  output logic             out_tlast,
  output logic             out_tuser   // [0] bad_format
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;
  logic [7:0]  data_byte, xor_check;
  logic [31:0] sum_check, rot_check;

  b85_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .char_code  (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  b85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  b85_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_cmd     (pop_cmd),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .data_byte   (data_byte),
    .last_of_run (out_tlast),
    .bad_format  (out_tuser),
    .xor_check   (xor_check),
    .sum_check   (sum_check),
    .rot_check   (rot_check)
  );

  assign out_tdata = {rot_check, sum_check, xor_check, data_byte};

endmodule
`default_nettype wire

[src/b85_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b85_front
// Accepts characters, classifies them and gathers base-85 digits into words.
// ----------------------------------------------------------------------------
module b85_front
  import b85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  output logic            push_valid,
  input  wire logic       push_ready,
  output cmd_t            push_cmd
);

  logic [31:0] word_r, word_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        error_r, error_nxt;
  logic [6:0]  digit;
  logic [31:0] acc_word;
  logic        is_digit;
  logic        accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign digit    = 7'(char_code - CHAR_DIGIT_LO);

  always_comb begin
    is_digit = char_code inside {[CHAR_DIGIT_LO:CHAR_DIGIT_HI]};
  end

  // The first digit of a group replaces the word, later digits scale it.
  assign acc_word = (count_r == 3'd0) ? 32'(digit)
                                      : 32'(word_r * RADIX) + 32'(digit);

  always_comb begin
    word_nxt      = word_r;
    count_nxt     = count_r;
    error_nxt     = error_r;
    push_valid    = 1'b0;
    push_cmd.err  = 1'b0;
    push_cmd.word = acc_word;
    if (accept) begin
      if (error_r) begin
        push_valid   = 1'b1;
        push_cmd.err = 1'b1;
      end else if (char_code == CHAR_NEWLINE) begin
        push_valid = 1'b0;
      end else if (char_code == CHAR_ZERO_WORD && count_r == 3'd0) begin
        push_valid    = 1'b1;
        push_cmd.word = 32'd0;
      end else if (is_digit) begin
        if (count_r < GROUP_LAST_DIGIT) begin
          word_nxt  = acc_word;
          count_nxt = count_r + 3'd1;
        end else begin
          push_valid = 1'b1;
          word_nxt   = 32'd0;
          count_nxt  = 3'd0;
        end
      end else begin
        error_nxt    = 1'b1;
        push_valid   = 1'b1;
        push_cmd.err = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= 32'd0;
      count_r <= 3'd0;
      error_r <= 1'b0;
    end else begin
      word_r  <= word_nxt;
      count_r <= count_nxt;
      error_r <= error_nxt;
    end
  end

endmodule
`default_nettype wire

[src/b85_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b85_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module b85_queue
  import b85_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[src/b85_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b85_back
// Splits queued words into bytes, keeps the checksums and drives the result
// register.
// ----------------------------------------------------------------------------
module b85_back
  import b85_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_cmd,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] data_byte,
  output logic       last_of_run,
  output logic       bad_format,
  output logic [7:0] xor_check,
  output logic [31:0] sum_check,
  output logic [31:0] rot_check
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] rot_r, rot_nxt;
  logic [7:0]  byte_r, byte_sel;
  logic        last_r, bad_r, last_sel;
  logic        load;

  assign load     = pop_valid && (!valid_r || out_ready);
  assign last_sel = pop_cmd.err || (idx_r == LAST_BYTE_IDX);
  assign pop_ready = load && last_sel;

  always_comb begin
    case (idx_r)
      2'd0:    byte_sel = pop_cmd.word[31:24];
      2'd1:    byte_sel = pop_cmd.word[23:16];
      2'd2:    byte_sel = pop_cmd.word[15:8];
      default: byte_sel = pop_cmd.word[7:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    xor_nxt   = xor_r;
    sum_nxt   = sum_r;
    rot_nxt   = rot_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_sel ? 2'd0 : idx_r + 2'd1;
      // An error result reports the checksums as they stand.
      if (!pop_cmd.err) begin
        xor_nxt = xor_r ^ byte_sel;
        sum_nxt = sum_r + 32'(byte_sel) + 32'd1;
        rot_nxt = {rot_r[30:0], rot_r[31]} + 32'(byte_sel);
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
      xor_r   <= 8'd0;
      sum_r   <= 32'd0;
      rot_r   <= 32'd0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      xor_r   <= xor_nxt;
      sum_r   <= sum_nxt;
      rot_r   <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= pop_cmd.err ? 8'd0 : byte_sel;
      last_r <= last_sel;
      bad_r  <= pop_cmd.err;
    end
  end

  assign out_valid   = valid_r;
  assign data_byte   = byte_r;
  assign last_of_run = last_r;
  assign bad_format  = bad_r;
  assign xor_check   = xor_r;
  assign sum_check   = sum_r;
  assign rot_check   = rot_r;

endmodule
`default_nettype wire
